### design/slt_pkg.sv
// ---------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the sector range lock table.
// ---------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

    localparam int LOCK_ENTRIES = 8;
    localparam int IDX_W        = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;

    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    localparam logic [1:0] STATUS_GRANTED  = 2'd0;
    localparam logic [1:0] STATUS_CONFLICT = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_UNLOCK   = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [31:0] start_sector;
        logic [15:0] sector_count;
        logic        read_only;
    } slt_req_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] status;
    } slt_rsp_t;

    typedef struct packed {
        logic overlap;
        logic match;
    } slt_cmp_t;

endpackage

`default_nettype wire

### design/slt_cmp_unit.sv
// ---------------------------------------------------------------------------
// slt_cmp_unit
// Range compare unit shared across the table scan: half-open overlap test
// with 33-bit ends, and exact start/count match.
// ---------------------------------------------------------------------------
`default_nettype none

module slt_cmp_unit (
    input  wire logic [31:0]       entry_start,
    input  wire logic [15:0]       entry_count,
    input  wire logic [31:0]       req_start,
    input  wire logic [15:0]       req_count,
    output slt_pkg::slt_cmp_t      cmp
);
    import slt_pkg::*;

    logic [32:0] entry_hi;
    logic [32:0] req_hi;

    assign entry_hi = {1'b0, entry_start} + {17'd0, entry_count};
    assign req_hi   = {1'b0, req_start} + {17'd0, req_count};

    assign cmp.overlap = ({1'b0, entry_start} < req_hi) && ({1'b0, req_start} < entry_hi);
    assign cmp.match   = (entry_start == req_start) && (entry_count == req_count);

endmodule

`default_nettype wire

### design/sector_range_lock_table.sv
// ---------------------------------------------------------------------------
// sector_range_lock_table
// Timing: the scan visits one table entry per cycle and stops early on a
// conflict or an unlock match; done is a registered pulse after the last
// entry visited. A lock that is granted or full always scans all
// LOCK_ENTRIES entries. The next word is taken in the done cycle.
// Reset clears all entries to free; done cannot be held off by the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module sector_range_lock_table (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire slt_pkg::slt_req_t request,
    output logic                   busy,
    output logic                   done,
    output slt_pkg::slt_rsp_t      result
);
    import slt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOCK_ENTRIES - 1);

    state_t           state_reg, state_next;
    slt_req_t         req_reg, req_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             have_free_reg, have_free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             done_reg, done_next;
    slt_rsp_t         rsp_reg, rsp_next;

    logic [LOCK_ENTRIES-1:0] valid_reg;
    logic [31:0]             start_mem [LOCK_ENTRIES];
    logic [15:0]             count_mem [LOCK_ENTRIES];
    logic                    ro_mem    [LOCK_ENTRIES];

    logic             ent_valid;
    logic             ent_ro;
    slt_cmp_t         cmp;
    logic             wr_en;
    logic             clr_en;
    logic [IDX_W-1:0] wr_idx;

    assign ent_valid = valid_reg[idx_reg];
    assign ent_ro    = ro_mem[idx_reg];

    slt_cmp_unit u_cmp (
        .entry_start (start_mem[idx_reg]),
        .entry_count (count_mem[idx_reg]),
        .req_start   (req_reg.start_sector),
        .req_count   (req_reg.sector_count),
        .cmp         (cmp)
    );

    always_comb
    begin
        logic             last;
        logic             free_now;
        logic [IDX_W-1:0] free_idx_now;

        state_next     = state_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        have_free_next = have_free_reg;
        free_idx_next  = free_idx_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        clr_en         = 1'b0;

        last         = (idx_reg == LAST_IDX);
        free_now     = have_free_reg | ~ent_valid;
        free_idx_now = have_free_reg ? free_idx_reg : idx_reg;
        wr_idx       = free_idx_now;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next       = request;
                    idx_next       = '0;
                    have_free_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (req_reg.operation == OP_UNLOCK)
                begin
                    if (ent_valid && cmp.match)
                    begin
                        clr_en = 1'b1;
                    end
                    if ((ent_valid && cmp.match) || last)
                    begin
                        done_next       = 1'b1;
                        rsp_next.accepted = 1'b1;
                        rsp_next.status = STATUS_UNLOCK;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (ent_valid && cmp.overlap && !(req_reg.read_only && ent_ro))
                begin
                    done_next         = 1'b1;
                    rsp_next.accepted = 1'b0;
                    rsp_next.status   = STATUS_CONFLICT;
                    state_next        = S_IDLE;
                end
                else if (last)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (free_now)
                    begin
                        wr_en             = 1'b1;
                        rsp_next.accepted = 1'b1;
                        rsp_next.status   = STATUS_GRANTED;
                    end
                    else
                    begin
                        rsp_next.accepted = 1'b0;
                        rsp_next.status   = STATUS_FULL;
                    end
                end
                else
                begin
                    have_free_next = free_now;
                    free_idx_next  = free_idx_now;
                    idx_next       = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            have_free_reg <= 1'b0;
            free_idx_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            have_free_reg <= have_free_next;
            free_idx_reg  <= free_idx_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
        else if (clr_en)
        begin
            valid_reg[idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_idx] <= req_reg.start_sector;
            count_mem[wr_idx] <= req_reg.sector_count;
            ro_mem[wr_idx]    <= req_reg.read_only;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

`default_nettype wire

### tb/sv/tb_sector_range_lock_table.sv
// ---------------------------------------------------------------------------
// tb_sector_range_lock_table
// Drives lock and unlock words into the sector range lock table. A short
// scripted sequence covers empty, full and conflicting tables, zero counts
// and the ends of the sector space. A random run follows, with locks packed
// into narrow sector windows and unlocks of ranges that are held. Each
// response is checked against its scripted value or the bench's table predictor.
// ---------------------------------------------------------------------------
module tb_sector_range_lock_table;
    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam int RANDOM_WORDS = 1125;
    localparam int QUIET_TAIL   = 150;

    localparam slt_rsp_t RSP_GRANT    = {1'b1, STATUS_GRANTED};
    localparam slt_rsp_t RSP_CONFLICT = {1'b0, STATUS_CONFLICT};
    localparam slt_rsp_t RSP_FULL     = {1'b0, STATUS_FULL};
    localparam slt_rsp_t RSP_UNLOCK   = {1'b1, STATUS_UNLOCK};
    localparam slt_rsp_t RSP_NONE     = '0;

    typedef struct packed {
        slt_req_t word;
        logic     typed;
        slt_rsp_t want;
    } script_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    slt_req_t request;
    logic     busy;
    logic     done;
    slt_rsp_t result;

    logic        held_valid [LOCK_ENTRIES];
    logic [31:0] held_start [LOCK_ENTRIES];
    logic [15:0] held_count [LOCK_ENTRIES];
    logic        held_ro    [LOCK_ENTRIES];

    slt_rsp_t    pending_responses [$];
    script_row_t lock_script [$];
    int          mismatch_count = 0;

    sector_range_lock_table DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic script_row_t script_row(input logic op, input logic [31:0] first,
                                               input logic [15:0] count, input logic ro,
                                               input logic typed, input slt_rsp_t want);
        script_row_t r;
        r.word.operation    = op;
        r.word.start_sector = first;
        r.word.sector_count = count;
        r.word.read_only    = ro;
        r.typed             = typed;
        r.want              = want;
        return r;
    endfunction

    function automatic slt_rsp_t predict_lock_response(input slt_req_t w);
        slt_rsp_t    rsp;
        logic [32:0] req_end;
        logic [32:0] ent_end;
        logic        have_free;
        logic        conflict;
        int          free_slot;
        int          i;
        have_free = 1'b0;
        conflict  = 1'b0;
        free_slot = 0;
        if (w.operation == OP_UNLOCK)
        begin
            for (i = 0; i < LOCK_ENTRIES; i++)
            begin
                if (held_valid[i] && held_start[i] == w.start_sector
                    && held_count[i] == w.sector_count)
                begin
                    held_valid[i] = 1'b0;
                    held_start[i] = '0;
                    held_count[i] = '0;
                    held_ro[i]    = 1'b0;
                    break;
                end
            end
            return RSP_UNLOCK;
        end
        req_end = {1'b0, w.start_sector} + w.sector_count;
        for (i = 0; i < LOCK_ENTRIES; i++)
        begin
            if (!held_valid[i])
            begin
                if (!have_free)
                begin
                    have_free = 1'b1;
                    free_slot = i;
                end
                continue;
            end
            ent_end = {1'b0, held_start[i]} + held_count[i];
            if (held_start[i] < req_end && w.start_sector < ent_end
                && !(w.read_only && held_ro[i]))
            begin
                conflict = 1'b1;
                break;
            end
        end
        if (conflict)
            rsp = RSP_CONFLICT;
        else if (!have_free)
            rsp = RSP_FULL;
        else
        begin
            held_valid[free_slot] = 1'b1;
            held_start[free_slot] = w.start_sector;
            held_count[free_slot] = w.sector_count;
            held_ro[free_slot]    = w.read_only;
            rsp = RSP_GRANT;
        end
        return rsp;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input slt_req_t w, input logic typed, input slt_rsp_t want);
        slt_rsp_t predicted;
        start   <= 1'b1;
        request <= w;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_lock_response(w);
        pending_responses.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        slt_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_responses.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual accepted=%0b status=%0d",
                         $time, result.accepted, result.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (result.accepted !== want.accepted)
                begin
                    $display("%0t: accepted mismatch, expected %0b, actual %0b",
                             $time, want.accepted, result.accepted);
                    mismatch_count++;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, result.status);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        slt_req_t    w;
        logic [31:0] window;
        logic        idle_on;
        int          pick;
        int          slot;
        int          n;
        int          i;
        int          guard;
        logic        found;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        for (i = 0; i < LOCK_ENTRIES; i++)
        begin
            held_valid[i] = 1'b0;
            held_start[i] = '0;
            held_count[i] = '0;
            held_ro[i]    = 1'b0;
        end

        lock_script.push_back(script_row(OP_UNLOCK, 32'd0, 16'd0, 1'b0, 1'b1, RSP_UNLOCK));
        lock_script.push_back(script_row(OP_LOCK, 32'd0, 16'd0, 1'b0, 1'b1, RSP_GRANT));
        lock_script.push_back(script_row(OP_LOCK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1,
                                         RSP_GRANT));
        lock_script.push_back(script_row(OP_LOCK, 32'd100, 16'd10, 1'b1, 1'b0, RSP_NONE));
        lock_script.push_back(script_row(OP_LOCK, 32'd105, 16'd2, 1'b1, 1'b0, RSP_NONE));
        lock_script.push_back(script_row(OP_LOCK, 32'd108, 16'd4, 1'b0, 1'b1, RSP_CONFLICT));
        lock_script.push_back(script_row(OP_LOCK, 32'd110, 16'd5, 1'b0, 1'b0, RSP_NONE));
        lock_script.push_back(script_row(OP_LOCK, 32'd112, 16'd0, 1'b0, 1'b1, RSP_CONFLICT));
        lock_script.push_back(script_row(OP_LOCK, 32'd110, 16'd0, 1'b0, 1'b0, RSP_NONE));
        lock_script.push_back(script_row(OP_LOCK, 32'd0, 16'd5, 1'b0, 1'b0, RSP_NONE));
        lock_script.push_back(script_row(OP_LOCK, 32'd1000, 16'd8, 1'b0, 1'b0, RSP_NONE));
        lock_script.push_back(script_row(OP_LOCK, 32'd2000, 16'd1, 1'b0, 1'b1, RSP_FULL));
        lock_script.push_back(script_row(OP_LOCK, 32'd1004, 16'd1, 1'b0, 1'b1, RSP_CONFLICT));
        lock_script.push_back(script_row(OP_LOCK, 32'hFFFF_FFFF, 16'd1, 1'b1, 1'b1, RSP_FULL));
        lock_script.push_back(script_row(OP_UNLOCK, 32'd100, 16'd9, 1'b0, 1'b1, RSP_UNLOCK));
        lock_script.push_back(script_row(OP_UNLOCK, 32'd100, 16'd10, 1'b1, 1'b1, RSP_UNLOCK));
        lock_script.push_back(script_row(OP_LOCK, 32'd2000, 16'd1, 1'b0, 1'b0, RSP_NONE));
        lock_script.push_back(script_row(OP_UNLOCK, 32'd0, 16'd0, 1'b0, 1'b1, RSP_UNLOCK));
        lock_script.push_back(script_row(OP_UNLOCK, 32'd0, 16'd0, 1'b1, 1'b1, RSP_UNLOCK));
        lock_script.push_back(script_row(OP_UNLOCK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1,
                                         RSP_UNLOCK));
        lock_script.push_back(script_row(OP_LOCK, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0,
                                         RSP_NONE));
        lock_script.push_back(script_row(OP_LOCK, 32'hFFFF_FFFE, 16'd2, 1'b0, 1'b1,
                                         RSP_CONFLICT));
        lock_script.push_back(script_row(OP_LOCK, 32'd0, 16'hFFFF, 1'b1, 1'b1, RSP_CONFLICT));
        lock_script.push_back(script_row(OP_LOCK, 32'd105, 16'd2, 1'b1, 1'b0, RSP_NONE));
        lock_script.push_back(script_row(OP_UNLOCK, 32'd105, 16'd2, 1'b0, 1'b1, RSP_UNLOCK));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (lock_script[k])
            send_word(lock_script[k].word, lock_script[k].typed, lock_script[k].want);

        window  = '0;
        idle_on = 1'b0;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 128 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       window = 32'd0;
                    1:       window = 32'hFFFF_FF00;
                    default: window = $urandom;
                endcase
                idle_on = ($urandom_range(0, 2) != 0);
            end
            pick        = $urandom_range(0, 99);
            w.read_only = 1'($urandom_range(0, 1));
            if (pick < 45)
            begin
                w.operation    = OP_LOCK;
                w.start_sector = window + $urandom_range(0, 255);
                w.sector_count = 16'($urandom_range(0, 24));
            end
            else if (pick < 85)
            begin
                w.operation    = OP_UNLOCK;
                w.start_sector = window + $urandom_range(0, 255);
                w.sector_count = 16'($urandom_range(0, 24));
                if (pick < 75)
                begin
                    slot  = $urandom_range(0, LOCK_ENTRIES - 1);
                    found = 1'b0;
                    for (i = 0; i < LOCK_ENTRIES && !found; i++)
                    begin
                        if (held_valid[(slot + i) % LOCK_ENTRIES])
                        begin
                            found          = 1'b1;
                            w.start_sector = held_start[(slot + i) % LOCK_ENTRIES];
                            w.sector_count = held_count[(slot + i) % LOCK_ENTRIES];
                        end
                    end
                end
            end
            else
            begin
                w.operation    = OP_LOCK;
                w.start_sector = $urandom;
                w.sector_count = 16'($urandom);
                if ($urandom_range(0, 3) == 0)
                    w.sector_count = (pick % 2 != 0) ? 16'hFFFF : 16'h0000;
            end
            if (idle_on && (n < RANDOM_WORDS - QUIET_TAIL) && $urandom_range(0, 5) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            send_word(w, 1'b0, RSP_NONE);
        end
        start <= 1'b0;

        for (guard = 0; guard < 1000 && pending_responses.size() != 0; guard++)
            @(posedge clk);
        repeat (LOCK_ENTRIES + 4) @(posedge clk);
        if (pending_responses.size() != 0)
        begin
            $display("%0t: %0d responses never arrived, expected accepted=%0b status=%0d",
                     $time, pending_responses.size(), pending_responses[0].accepted,
                     pending_responses[0].status);
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
design/slt_pkg.sv
design/slt_cmp_unit.sv
design/sector_range_lock_table.sv
tb/sv/tb_sector_range_lock_table.sv
